@@ src/rar_pkg.sv @@
// Shared types and constants for the rational add-and-reduce block.
package rar_pkg;

  // Field widths of the request and response words.
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 31;
  // Width of the exact intermediates (products, sum, divider operands).
  localparam int unsigned WIDE_W = 64;
  // Divider step counter, able to hold WIDE_W itself.
  localparam int unsigned CNT_W  = 7;
  // Count of common factors of two removed during the binary GCD.
  localparam int unsigned K_W    = 6;

  typedef struct packed {
    logic signed [NUM_W-1:0] lhs_numerator;
    logic        [DEN_W-1:0] lhs_denominator;
    logic signed [NUM_W-1:0] rhs_numerator;
    logic        [DEN_W-1:0] rhs_denominator;
  } req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] sum_numerator;
    logic        [DEN_W-1:0] sum_denominator;
    logic                    lhs_less;
    logic                    overflow;
  } rsp_t;

  // Which product the shared multiplier forms in a given cycle.
  typedef enum logic [1:0] {
    MUL_P1  = 2'b00,
    MUL_P2  = 2'b01,
    MUL_DEN = 2'b10
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum_en;
    logic     gcd_init;
    logic     gcd_step;
    logic     shift_en;
    logic     div_start;
    logic     out_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

@@ src/rar_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rar_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rar_pkg::WIDE_W-1:0]  dividend_i,
  input  logic [rar_pkg::WIDE_W-1:0]  divisor_i,
  output logic [rar_pkg::WIDE_W-1:0]  quotient_o,
  output logic                        done_o
);

  localparam int unsigned W  = rar_pkg::WIDE_W;
  localparam int unsigned CW = rar_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LOAD = CW'(W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic          active_q, active_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, quo_q, dvs_q;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  end

  // Step counter: the last step is the one taken while the count reads one.
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_LOAD;
    end else if (active_q) begin
      cnt_d = cnt_q - CNT_ONE;
      if (cnt_q == CNT_ONE) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      if (!diff[W+1]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = active_q && (cnt_q == CNT_ONE);

endmodule

@@ src/rar_dpath.sv @@
// Datapath: shared multiplier, sum and compare, binary GCD and two dividers.
module rar_dpath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rar_pkg::req_t req_i,
  input  rar_pkg::cmd_t cmd_i,
  output rar_pkg::sts_t sts_o,
  output rar_pkg::rsp_t rsp_o
);

  localparam int unsigned W  = rar_pkg::WIDE_W;
  localparam int unsigned NW = rar_pkg::NUM_W;
  localparam int unsigned DW = rar_pkg::DEN_W;
  localparam int unsigned KW = rar_pkg::K_W;
  localparam logic [W-1:0] HALF = W'(1) << (WIDTH - 1);

  rar_pkg::req_t          op_q;
  logic signed [NW:0]     mul_a;
  logic signed [NW-1:0]   mul_b;
  logic signed [W:0]      mul_p;
  logic signed [W-1:0]    p1_q, p2_q, num_q;
  logic [W-1:0]           den_q, num_mag, mag_q;
  logic                   less_q, neg_q;
  logic [W-1:0]           a_q, b_q, g_q;
  logic [KW-1:0]          k_q;
  logic [W:0]             diff_ab, diff_ba;
  logic [W-1:0]           quo_num, quo_den;
  logic                   done_num, done_den;
  logic                   fits;
  rar_pkg::rsp_t          rsp_q;

  // Capture the request word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i;
    end
  end

  // One shared multiplier forms the two cross products and the denominator.
  always_comb begin
    case (cmd_i.mul_sel)
      rar_pkg::MUL_P1: begin
        mul_a = {op_q.lhs_numerator[NW-1], op_q.lhs_numerator};
        mul_b = {1'b0, op_q.rhs_denominator};
      end
      rar_pkg::MUL_P2: begin
        mul_a = {op_q.rhs_numerator[NW-1], op_q.rhs_numerator};
        mul_b = {1'b0, op_q.lhs_denominator};
      end
      rar_pkg::MUL_DEN: begin
        mul_a = {2'b00, op_q.lhs_denominator};
        mul_b = {1'b0, op_q.rhs_denominator};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        rar_pkg::MUL_P1:  p1_q  <= mul_p[W-1:0];
        rar_pkg::MUL_P2:  p2_q  <= mul_p[W-1:0];
        rar_pkg::MUL_DEN: den_q <= mul_p[W-1:0];
        default: ;
      endcase
    end
  end

  // Cross-multiplied sum and the exact comparison of the two fractions.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      num_q  <= p1_q + p2_q;
      less_q <= p1_q < p2_q;
    end
  end

  // Magnitude of the sum, which cannot exceed the wide range.
  assign num_mag = num_q[W-1] ? (W'(0) - W'(num_q)) : W'(num_q);

  // Binary GCD: one halving or one subtract-and-halve each cycle.
  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      a_q   <= den_q;
      b_q   <= num_mag;
      k_q   <= '0;
      neg_q <= num_q[W-1];
      mag_q <= num_mag;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (!diff_ab[W]) begin
        a_q <= {1'b0, diff_ab[W-1:1]};
      end else begin
        b_q <= {1'b0, diff_ba[W-1:1]};
      end
    end
  end

  // Restore the common factors of two.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      g_q <= a_q << k_q;
    end
  end

  // Both terms are divided by the GCD side by side.
  rar_div u_div_num (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_q),
    .divisor_i  (g_q),
    .quotient_o (quo_num),
    .done_o     (done_num)
  );

  rar_div u_div_den (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (den_q),
    .divisor_i  (g_q),
    .quotient_o (quo_den),
    .done_o     (done_den)
  );

  // Range check of the reduced fraction against the result width.
  assign fits = (neg_q ? (quo_num <= HALF) : (quo_num < HALF)) && (quo_den < HALF);

  // Result word, with the zero-sum and undefined cases folded in.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      rsp_q.lhs_less <= less_q;
      if (den_q == '0) begin
        rsp_q.sum_numerator   <= '0;
        rsp_q.sum_denominator <= DW'(1);
        rsp_q.overflow        <= 1'b1;
      end else if (num_q == '0 || !fits) begin
        rsp_q.sum_numerator   <= '0;
        rsp_q.sum_denominator <= DW'(1);
        rsp_q.overflow        <= (num_q != '0);
      end else begin
        rsp_q.sum_numerator   <= neg_q ? (NW'(0) - quo_num[NW-1:0]) : quo_num[NW-1:0];
        rsp_q.sum_denominator <= quo_den[DW-1:0];
        rsp_q.overflow        <= 1'b0;
      end
    end
  end

  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.num_zero = (num_q == '0);
  assign sts_o.gcd_done = a_q[0] && b_q[0] && (diff_ab == '0);
  assign sts_o.div_done = done_num && done_den;
  assign rsp_o          = rsp_q;

endmodule

@@ src/rar_ctrl.sv @@
// Controller: sequences the datapath through one word from start to result.
module rar_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rar_pkg::sts_t sts_i,
  output rar_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MUL0   = 11'b000_0000_0010,
    S_MUL1   = 11'b000_0000_0100,
    S_MUL2   = 11'b000_0000_1000,
    S_SUM    = 11'b000_0001_0000,
    S_MAG    = 11'b000_0010_0000,
    S_GCD    = 11'b000_0100_0000,
    S_SHIFT  = 11'b000_1000_0000,
    S_DSTART = 11'b001_0000_0000,
    S_DIV    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  // Next state and the commands issued in each state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_P1;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_P2;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_DEN;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = S_MAG;
      end
      S_MAG: begin
        // A zero denominator or a zero sum needs no reduction.
        if (sts_i.den_zero || sts_i.num_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          state_d = S_SHIFT;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        state_d        = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_en = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DONE);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ src/rational_add_reduce.sv @@
// Top level: adds two fractions and reduces the sum to lowest terms.
// The time from the accepting edge to the done strobe is set by the dividers and by
// the binary GCD loop, whose steps depend on the bit lengths of the two terms.
// One word is in flight at a time; start is taken again in the cycle done_o shows.
// Reset clears the controller to idle with no result pending; the receiver cannot stall.
module rational_add_reduce #(
  parameter int unsigned WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rar_pkg::req_t req_i,
  output rar_pkg::rsp_t rsp_o,
  output logic          done_o
);

  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;

  // Sequencer.
  rar_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Arithmetic.
  rar_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTHESIS
  // The result word is shown only once the controller is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted word always starts the sequence.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // An overflowed result reads as zero over one.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.overflow) |->
      (rsp_o.sum_numerator == '0 && rsp_o.sum_denominator == 31'd1))
    else $error("overflow result is not 0/1");

  // A delivered denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.sum_denominator != '0))
    else $error("zero denominator delivered");
`endif

endmodule

@@ tb/sv/rational_add_reduce_tb.sv @@
// Self-checking testbench for the rational add-and-reduce block.
module rational_add_reduce_tb;

  localparam int unsigned WIDTH        = 32;
  localparam int          NUM_MAX      = 32'sh7FFF_FFFF;
  localparam int          NUM_MIN      = 32'sh8000_0000;
  localparam int unsigned DEN_MAX      = 32'h7FFF_FFFF;
  localparam int unsigned RANDOM_WORDS = 1430;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 250;

  // Keeps the expected sums in order and compares each result word against the oldest.
  class rational_sum_board;
    rar_pkg::rsp_t pending_sums[$];
    int unsigned   mismatches;

    // Works out the reduced sum and the comparison flag for one pair of fractions.
    function void note_operands(rar_pkg::req_t w);
      longint          lhs_cross, rhs_cross, total;
      longint unsigned den_prod, mag, a, b, r, half, red_n, red_d;
      rar_pkg::rsp_t   want;
      bit              neg;
      lhs_cross = longint'($signed(w.lhs_numerator)) * longint'(w.rhs_denominator);
      rhs_cross = longint'($signed(w.rhs_numerator)) * longint'(w.lhs_denominator);
      total     = lhs_cross + rhs_cross;
      den_prod  = 64'(w.lhs_denominator) * 64'(w.rhs_denominator);
      want                 = '0;
      want.sum_denominator = 31'd1;
      want.lhs_less        = (lhs_cross < rhs_cross);
      if (den_prod == 0) begin
        // An undefined sum reads 0/1 with the overflow flag raised.
        want.overflow = 1'b1;
      end else if (total != 0) begin
        neg = (total < 0);
        mag = neg ? -total : total;
        // Euclid's remainder loop for the common divisor.
        a = den_prod;
        b = mag;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        red_n = mag / a;
        red_d = den_prod / a;
        half  = 64'd1 << (WIDTH - 1);
        if ((neg ? red_n <= half : red_n < half) && red_d < half) begin
          want.sum_numerator   = neg ? 32'(-red_n) : 32'(red_n);
          want.sum_denominator = 31'(red_d);
        end else begin
          want.overflow = 1'b1;
        end
      end
      pending_sums.push_back(want);
    endfunction

    function void report_field(string field, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatches++;
    endfunction

    // Compares one result word field by field with the oldest expectation.
    function void check_sum(rar_pkg::rsp_t got);
      rar_pkg::rsp_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: result word %0d/%0d arrived with none expected", $time,
                 $signed(got.sum_numerator), got.sum_denominator);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (got.sum_numerator !== want.sum_numerator)
          report_field("sum_numerator", $signed(want.sum_numerator),
                       $signed(got.sum_numerator));
        if (got.sum_denominator !== want.sum_denominator)
          report_field("sum_denominator", want.sum_denominator, got.sum_denominator);
        if (got.lhs_less !== want.lhs_less)
          report_field("lhs_less", want.lhs_less, got.lhs_less);
        if (got.overflow !== want.overflow)
          report_field("overflow", want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  rar_pkg::req_t req_i  = '0;
  logic          busy;
  rar_pkg::rsp_t rsp_o;
  logic          done_o;

  rational_sum_board board = new();
  int unsigned       quiet_cycles = 0;

  rational_add_reduce #(
    .WIDTH(WIDTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

  always #10 clk_i = ~clk_i;

  // Packs the four operand fields into one request word.
  function automatic rar_pkg::req_t operands(int lhs_n, int unsigned lhs_d,
                                             int rhs_n, int unsigned rhs_d);
    rar_pkg::req_t w;
    w.lhs_numerator   = lhs_n;
    w.lhs_denominator = lhs_d[30:0];
    w.rhs_numerator   = rhs_n;
    w.rhs_denominator = rhs_d[30:0];
    return w;
  endfunction

  // Signed value of random magnitude up to span.
  function automatic int signed_upto(int unsigned span);
    int m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(input rar_pkg::req_t w);
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Notes accepted words, checks results and watches for a stalled block.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_sum(rsp_o);
    if (rst_ni && start && !busy) board.note_operands(req_i);
    if (rst_ni && (done_o || (start && !busy))) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rational_add_reduce_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int            mode;
    int unsigned   f, k;
    bit            idle_ok;
    rar_pkg::req_t w;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, zero sums, zero denominators and overflow.
    send_word(operands(1, 2, 1, 3));
    send_word(operands(1, 2, -1, 2));
    send_word(operands(0, 1, 0, 1));
    send_word(operands(0, 5, 3, 0));
    send_word(operands(3, 0, 1, 1));
    send_word(operands(0, 0, 0, 0));
    send_word(operands(NUM_MAX, 1, NUM_MAX, 1));
    send_word(operands(NUM_MAX, 1, 0, 1));
    send_word(operands(NUM_MAX, 1, 1, 1));
    send_word(operands(NUM_MIN, 1, 0, 1));
    send_word(operands(NUM_MIN, 1, -1, 1));
    send_word(operands(NUM_MIN, 1, NUM_MIN, 1));
    send_word(operands(1, DEN_MAX, 1, DEN_MAX));
    send_word(operands(1, DEN_MAX, 1, DEN_MAX - 1));
    send_word(operands(NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX));
    send_word(operands(NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX));
    send_word(operands(6, 4, 9, 6));
    send_word(operands(-7, 3, 2, 5));
    send_word(operands(2, 5, -7, 3));
    send_word(operands(4, 6, 2, 3));
    send_word(operands(-1, DEN_MAX, -1, DEN_MAX));
    send_word(operands(NUM_MIN, 1, NUM_MAX, DEN_MAX));
    send_word(operands(1, 1, -1, 2));

    // Hold off until every directed result has come back.
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending_sums.size() != 0);

    // Random words drawn from several shapes of operand.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      mode                = $urandom_range(0, 15);
      w.lhs_numerator     = $urandom;
      w.lhs_denominator   = 31'($urandom);
      w.rhs_numerator     = $urandom;
      w.rhs_denominator   = 31'($urandom);
      case (mode)
        3, 4, 5: begin
          w = operands(signed_upto(1000), $urandom_range(1, 100),
                       signed_upto(1000), $urandom_range(1, 100));
        end
        6, 7, 8: begin
          // Denominators that share a factor, so the sum reduces.
          f = $urandom_range(1, 1 << 12);
          w = operands(signed_upto(1 << 20), f * $urandom_range(1, 64),
                       signed_upto(1 << 20), f * $urandom_range(1, 64));
        end
        9, 10: begin
          w.lhs_numerator   = $signed($urandom) >>> $urandom_range(0, 31);
          w.lhs_denominator = 31'($urandom >> $urandom_range(1, 31));
          w.rhs_numerator   = $signed($urandom) >>> $urandom_range(0, 31);
          w.rhs_denominator = 31'($urandom >> $urandom_range(1, 31));
        end
        11, 12: begin
          // The right fraction is the negated left one, scaled up.
          f = $urandom_range(1, 1 << 12);
          k = $urandom_range(1, 64);
          w.lhs_numerator   = signed_upto(1 << 24);
          w.lhs_denominator = 31'(f);
          w.rhs_numerator   = -w.lhs_numerator * int'(k);
          w.rhs_denominator = 31'(f * k);
        end
        13: begin
          // Integers close to the ends of the numerator range.
          w = operands($urandom_range(0, 1) ? NUM_MAX - int'($urandom_range(0, 4))
                                            : NUM_MIN + int'($urandom_range(0, 4)),
                       1, signed_upto(8), 1);
        end
        14: begin
          w.lhs_denominator = 31'($urandom) | 31'd1;
          w.rhs_denominator = w.lhs_denominator;
        end
        15: begin
          if ($urandom_range(0, 1)) w.lhs_denominator = '0;
          else w.rhs_denominator = '0;
        end
        default: ;
      endcase
      send_word(w);

      // Idle bursts, either while the block works or once it has gone idle.
      idle_ok = (i < RANDOM_WORDS - CALM_TAIL) && ((i / 60) % 4 != 3);
      if (idle_ok && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk_i); while (busy);
        end
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end

    // Drain the outstanding result, then allow for any stray strobe.
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending_sums.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("rational_add_reduce_tb: PASS");
    end else begin
      $display("rational_add_reduce_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rar_pkg.sv
src/rar_div.sv
src/rar_dpath.sv
src/rar_ctrl.sv
src/rational_add_reduce.sv
tb/sv/rational_add_reduce_tb.sv
